>>> src/srch_pkg.sv
// Package with shared types and constants for the segment ray cast block.
package srch_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_RAY_START_X = 3'd0;
    localparam logic [2:0] REG_RAY_START_Y = 3'd1;
    localparam logic [2:0] REG_RAY_END_X   = 3'd2;
    localparam logic [2:0] REG_RAY_END_Y   = 3'd3;
    localparam logic [2:0] REG_FILT_GROUPS = 3'd4;
    localparam logic [2:0] REG_FILT_MASK   = 3'd5;

    // Handshake between the control sequencer and the serial units.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } srch_ctl_t;

endpackage

>>> src/srch_mul.sv
// Serial shift-and-add signed multiplier, one multiplier bit per cycle.
module srch_mul #(
    parameter int A_BITS = 26,
    parameter int B_BITS = 26
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic signed [A_BITS-1:0]    a,
    input  logic signed [B_BITS-1:0]    b,
    output srch_pkg::srch_ctl_t         ctl,
    output logic signed [A_BITS+B_BITS-1:0] prod
);
    localparam int PW = A_BITS + B_BITS;
    localparam int CW = $clog2(B_BITS + 1);

    logic signed [PW-1:0] acc_reg, acc_next;
    logic signed [PW-1:0] mcand_reg, mcand_next;
    logic [B_BITS-1:0]    mplier_reg, mplier_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next, done_reg, done_next;

    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start) begin
            acc_next    = '0;
            mcand_next  = PW'(a);
            mplier_next = b;
            cnt_next    = CW'(B_BITS);
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            // Top multiplier bit has negative weight (two's complement).
            if (mplier_reg[0]) begin
                if (cnt_reg == CW'(1)) acc_next = acc_reg - mcand_reg;
                else                   acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign prod      = acc_reg;
endmodule

>>> src/srch_div.sv
// Restoring divider giving one quotient bit per cycle.
module srch_div #(
    parameter int N_BITS = 53,
    parameter int Q_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [N_BITS-1:0]   num,
    input  logic [N_BITS-1:0]   den,
    output srch_pkg::srch_ctl_t ctl,
    output logic [Q_BITS-1:0]   quo
);
    localparam int CW = $clog2(Q_BITS + 1);

    logic [N_BITS:0]   rem_reg, rem_next;
    logic [N_BITS-1:0] den_reg, den_next;
    logic [Q_BITS-1:0] quo_reg, quo_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next, done_reg, done_next;
    logic [N_BITS:0]   shl;

    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shl       = {rem_reg[N_BITS-1:0], 1'b0};
        if (start) begin
            rem_next  = {1'b0, num};
            den_next  = den;
            quo_next  = '0;
            cnt_next  = CW'(Q_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shl >= {1'b0, den_reg}) begin
                rem_next = shl - {1'b0, den_reg};
                quo_next = {quo_reg[Q_BITS-2:0], 1'b1};
            end else begin
                rem_next = shl;
                quo_next = {quo_reg[Q_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign quo       = quo_reg;
endmodule

>>> src/segment_raycast_closest_hit.sv
// Top level of the closest-hit ray cast against a stream of edge segments.
// A filtered-out segment goes from IDLE straight to UPD; a tested one runs the six cross
// product multiplies and CHECK, then for a hit the divide, HX and HY, before UPD, and OUT
// follows the last segment; an alpha of exactly one skips the divider.
// A new segment is taken only once the last one is through: one serial multiplier and one
// restoring divider, each retiring one bit per cycle; reset (aresetn low, synchronous) clears
// the state, configuration and best hit registers and the result valid.
module segment_raycast_closest_hit #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 8,
    parameter int ALPHA_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [2:0]                   cfg_index,
    input  logic [31:0]                  cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_seg_start_x,
    input  logic signed [COORD_BITS-1:0] s_seg_start_y,
    input  logic signed [COORD_BITS-1:0] s_seg_end_x,
    input  logic signed [COORD_BITS-1:0] s_seg_end_y,
    input  logic [31:0]                  s_owner_groups,
    input  logic [31:0]                  s_owner_mask,
    input  logic                         s_last_segment,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_hit_found,
    output logic signed [COORD_BITS-1:0] m_hit_x,
    output logic signed [COORD_BITS-1:0] m_hit_y,
    output logic [ALPHA_BITS:0]          m_hit_alpha
);
    // Differences need one more bit; cross products twice that.
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int XW = PW + 1;
    localparam int AW = ALPHA_BITS + 1;
    localparam int MW = DW + AW + 1;
    // FRAC_BITS moves only the binary point; the arithmetic is unaffected.
    localparam int FRAC_UNUSED = FRAC_BITS;

    typedef enum logic [3:0] {
        ST_IDLE, ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5,
        ST_CHECK, ST_DIV, ST_HX, ST_HY, ST_UPD, ST_OUT
    } state_t;

    state_t state_reg, state_next;

    logic signed [COORD_BITS-1:0] rsx_reg, rsy_reg, rex_reg, rey_reg;
    logic [31:0] fgroups_reg, fmask_reg;

    // Segment operands captured at accept.
    logic signed [DW-1:0] rdx_reg, rdy_reg, sdx_reg, sdy_reg, dx_reg, dy_reg;
    logic last_reg;
    // Cross product partial products and results.
    logic signed [PW-1:0] p_reg [6];
    logic signed [XW-1:0] den_w, tn_w, un_w;
    logic [AW-1:0] alpha_reg;
    logic signed [COORD_BITS-1:0] hx_reg;

    logic have_hit_reg;
    logic [AW-1:0] best_alpha_reg;
    logic signed [COORD_BITS-1:0] best_x_reg, best_y_reg;

    logic out_valid_reg, out_found_reg;
    logic signed [COORD_BITS-1:0] out_x_reg, out_y_reg;
    logic [AW-1:0] out_alpha_reg;

    // Shared serial multiplier operands.
    logic mul_start;
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [2*MW-1:0] mul_p;
    srch_pkg::srch_ctl_t mul_ctl;
    logic div_start;
    srch_pkg::srch_ctl_t div_ctl;
    logic [ALPHA_BITS-1:0] div_q;
    logic [XW-2:0] div_num, div_den;
    logic busy_pulse_reg;

    logic signed [XW-1:0] den_abs, tn_n, un_n;
    logic hit_ok, full_alpha;
    logic signed [2*MW-1:0] fl;
    logic signed [COORD_BITS-1:0] h_next;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_ready   = (state_reg == ST_IDLE) && !out_valid_reg;

    srch_mul #(.A_BITS(MW), .B_BITS(MW)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mul_a), .b(mul_b), .ctl(mul_ctl), .prod(mul_p)
    );

    srch_div #(.N_BITS(XW - 1), .Q_BITS(ALPHA_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_num), .den(div_den), .ctl(div_ctl), .quo(div_q)
    );

    // Cross products, sign normalization and the hit window test.
    always_comb begin
        den_w = XW'(p_reg[0]) - XW'(p_reg[1]);
        tn_w  = XW'(p_reg[2]) - XW'(p_reg[3]);
        un_w  = XW'(p_reg[4]) - XW'(p_reg[5]);
        den_abs = den_w;
        tn_n    = tn_w;
        un_n    = un_w;
        if (den_w[XW-1]) begin
            den_abs = -den_w;
            tn_n    = -tn_w;
            un_n    = -un_w;
        end
        hit_ok = (den_abs != '0) && !tn_n[XW-1] && !un_n[XW-1] &&
                 (tn_n <= den_abs) && (un_n <= den_abs);
        full_alpha = (tn_n == den_abs);
        div_num = tn_n[XW-2:0];
        div_den = den_abs[XW-2:0];
    end

    // Operand selection for the shared multiplier per step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_M0: begin mul_a = MW'(rdx_reg); mul_b = MW'(sdy_reg); end
            ST_M1: begin mul_a = MW'(rdy_reg); mul_b = MW'(sdx_reg); end
            ST_M2: begin mul_a = MW'(dx_reg);  mul_b = MW'(sdy_reg); end
            ST_M3: begin mul_a = MW'(dy_reg);  mul_b = MW'(sdx_reg); end
            ST_M4: begin mul_a = MW'(dx_reg);  mul_b = MW'(rdy_reg); end
            ST_M5: begin mul_a = MW'(dy_reg);  mul_b = MW'(rdx_reg); end
            ST_HX: begin mul_a = MW'(rdx_reg); mul_b = MW'({1'b0, alpha_reg}); end
            ST_HY: begin mul_a = MW'(rdy_reg); mul_b = MW'({1'b0, alpha_reg}); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // Arithmetic shift is the floor of the division by 2^ALPHA_BITS.
    assign fl     = mul_p >>> ALPHA_BITS;
    assign h_next = COORD_BITS'(fl) + ((state_reg == ST_HX) ? rsx_reg : rsy_reg);

    always_comb begin
        state_next = state_reg;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    if (((s_owner_mask & fgroups_reg) != '0) &&
                        ((s_owner_groups & fmask_reg) != '0)) begin
                        state_next = ST_M0;
                    end else begin
                        state_next = ST_UPD;
                    end
                end
            end
            ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_HX, ST_HY: begin
                mul_start = busy_pulse_reg;
                if (mul_ctl.done) begin
                    case (state_reg)
                        ST_M0: state_next = ST_M1;
                        ST_M1: state_next = ST_M2;
                        ST_M2: state_next = ST_M3;
                        ST_M3: state_next = ST_M4;
                        ST_M4: state_next = ST_M5;
                        ST_M5: state_next = ST_CHECK;
                        ST_HX: state_next = ST_HY;
                        default: state_next = ST_UPD;
                    endcase
                end
            end
            ST_CHECK: begin
                if (!hit_ok) begin
                    state_next = ST_UPD;
                end else if (full_alpha) begin
                    state_next = ST_HX;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_ctl.done) state_next = ST_HX;
            end
            ST_UPD: state_next = last_reg ? ST_OUT : ST_IDLE;
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            rsx_reg        <= '0;
            rsy_reg        <= '0;
            rex_reg        <= '0;
            rey_reg        <= '0;
            fgroups_reg    <= '0;
            fmask_reg      <= '0;
            have_hit_reg   <= 1'b0;
            best_alpha_reg <= '0;
            best_x_reg     <= '0;
            best_y_reg     <= '0;
            out_valid_reg  <= 1'b0;
            busy_pulse_reg <= 1'b0;
            last_reg       <= 1'b0;
            alpha_reg      <= '0;
        end else begin
            state_reg <= state_next;
            // The multiplier is started once on entry to each multiply step.
            busy_pulse_reg <= (state_next != state_reg) &&
                              (state_next == ST_M0 || state_next == ST_M1 ||
                               state_next == ST_M2 || state_next == ST_M3 ||
                               state_next == ST_M4 || state_next == ST_M5 ||
                               state_next == ST_HX || state_next == ST_HY);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    srch_pkg::REG_RAY_START_X: rsx_reg <= cfg_data[COORD_BITS-1:0];
                    srch_pkg::REG_RAY_START_Y: rsy_reg <= cfg_data[COORD_BITS-1:0];
                    srch_pkg::REG_RAY_END_X:   rex_reg <= cfg_data[COORD_BITS-1:0];
                    srch_pkg::REG_RAY_END_Y:   rey_reg <= cfg_data[COORD_BITS-1:0];
                    srch_pkg::REG_FILT_GROUPS: fgroups_reg <= cfg_data;
                    srch_pkg::REG_FILT_MASK:   fmask_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) out_valid_reg <= 1'b0;
            if (s_valid && s_ready) last_reg <= s_last_segment;
            if (state_reg == ST_CHECK) alpha_reg <= AW'(1) << ALPHA_BITS;
            if (div_ctl.done) alpha_reg <= AW'(div_q);
            // A hit replaces the stored one only when strictly closer.
            if (state_reg == ST_HY && mul_ctl.done &&
                (!have_hit_reg || alpha_reg < best_alpha_reg)) begin
                have_hit_reg   <= 1'b1;
                best_alpha_reg <= alpha_reg;
                best_x_reg     <= hx_reg;
                best_y_reg     <= h_next;
            end
            if (state_reg == ST_OUT) begin
                out_valid_reg  <= 1'b1;
                have_hit_reg   <= 1'b0;
                best_alpha_reg <= '0;
                best_x_reg     <= '0;
                best_y_reg     <= '0;
            end
        end
        if (s_valid && s_ready) begin
            rdx_reg <= DW'(rex_reg) - DW'(rsx_reg);
            rdy_reg <= DW'(rey_reg) - DW'(rsy_reg);
            sdx_reg <= DW'(s_seg_end_x) - DW'(s_seg_start_x);
            sdy_reg <= DW'(s_seg_end_y) - DW'(s_seg_start_y);
            dx_reg  <= DW'(s_seg_start_x) - DW'(rsx_reg);
            dy_reg  <= DW'(s_seg_start_y) - DW'(rsy_reg);
        end
        if (mul_ctl.done) begin
            case (state_reg)
                ST_M0: p_reg[0] <= PW'(mul_p);
                ST_M1: p_reg[1] <= PW'(mul_p);
                ST_M2: p_reg[2] <= PW'(mul_p);
                ST_M3: p_reg[3] <= PW'(mul_p);
                ST_M4: p_reg[4] <= PW'(mul_p);
                ST_M5: p_reg[5] <= PW'(mul_p);
                ST_HX: hx_reg <= h_next;
                default: ;
            endcase
        end
        if (state_reg == ST_OUT) begin
            out_found_reg <= have_hit_reg;
            out_x_reg     <= best_x_reg;
            out_y_reg     <= best_y_reg;
            out_alpha_reg <= best_alpha_reg;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_hit_found = out_found_reg;
    assign m_hit_x     = out_x_reg;
    assign m_hit_y     = out_y_reg;
    assign m_hit_alpha = out_alpha_reg;
endmodule

>>> src/srch_checker.sv
// Port-level checker for the segment ray cast block, bound to the top level.
module srch_checker #(
    parameter int COORD_BITS = 24,
    parameter int ALPHA_BITS = 16
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  cfg_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_hit_found,
    input logic [COORD_BITS-1:0] m_hit_x,
    input logic [ALPHA_BITS:0]   m_hit_alpha
);
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit_x))
        else $error("result changed while stalled");
    a_no_hit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit_found |-> m_hit_alpha == '0 && m_hit_x == '0)
        else $error("empty result not zero");
    a_alpha_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_hit_alpha <= ((ALPHA_BITS+1)'(1) << ALPHA_BITS))
        else $error("alpha above one");
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && !cfg_ready)
        else $error("accepted while working");
endmodule

bind segment_raycast_closest_hit srch_checker #(
    .COORD_BITS(COORD_BITS), .ALPHA_BITS(ALPHA_BITS)
) u_srch_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .cfg_ready(cfg_ready), .m_valid(m_valid), .m_ready(m_ready),
    .m_hit_found(m_hit_found), .m_hit_x(m_hit_x), .m_hit_alpha(m_hit_alpha)
);
